FILE: design/tma_pkg.sv
package tma_pkg;

  // Fixed field widths of the channels
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned NB_W   = 11;

  // Neighbor code for "no triangle across this edge"
  localparam logic signed [NB_W-1:0] NB_NONE = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;    // capture query slot, clear neighbors, read queried entry
    logic write;    // write the incoming triangle into the store
    logic latch_q;  // hold the queried triangle for comparison
    logic issue;    // read the entry at the scan index and advance it
    logic finish;   // move neighbors into the result register
  } tma_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_ok;     // incoming slot lies inside the store
    logic limit_zero;  // nothing to scan
    logic scan_last;   // scan index is at the last slot to scan
    logic out_free;    // result register can take a new result
  } tma_sts_t;

endpackage

FILE: design/tma_ctrl.sv
module tma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_ready,
  input  tma_pkg::tma_sts_t   sts,
  output tma_pkg::tma_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QLOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic is_query;

  assign is_query = (in_opcode == tma_pkg::OP_QUERY);

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (is_query) begin
            cmd.start = 1'b1;
            state_nxt = sts.slot_ok ? ST_QLOAD : ST_DONE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_QLOAD: begin
        cmd.latch_q = 1'b1;
        state_nxt   = sts.limit_zero ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/tma_dp.sv
module tma_dp #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int VERTEX_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [tma_pkg::SLOT_W-1:0]          in_slot,
  input  logic [VERTEX_BITS-1:0]              in_vertex_a,
  input  logic [VERTEX_BITS-1:0]              in_vertex_b,
  input  logic [VERTEX_BITS-1:0]              in_vertex_c,
  input  logic                                cfg_valid,
  input  logic [tma_pkg::CNT_W-1:0]           cfg_triangle_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tma_pkg::NB_W-1:0]     out_neighbor_ab,
  output logic signed [tma_pkg::NB_W-1:0]     out_neighbor_bc,
  output logic signed [tma_pkg::NB_W-1:0]     out_neighbor_ca,
  input  tma_pkg::tma_cmd_t                   cmd,
  output tma_pkg::tma_sts_t                   sts
);

  localparam int AW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int TRI_W = 3 * VERTEX_BITS;

  logic [TRI_W-1:0]                mem [MAX_TRIANGLES];
  logic [TRI_W-1:0]                rd_data_r;
  logic [AW-1:0]                   rd_addr;
  logic [TRI_W-1:0]                q_r;
  logic [tma_pkg::SLOT_W-1:0]      qslot_r;
  logic [tma_pkg::CNT_W-1:0]       count_r;
  logic [tma_pkg::CNT_W-1:0]       limit;
  logic [tma_pkg::CNT_W-1:0]       scan_idx_r;
  logic [tma_pkg::CNT_W-1:0]       cmp_idx_r;
  logic                            issue_d_r;
  logic signed [tma_pkg::NB_W-1:0] nb_r [3];
  logic signed [tma_pkg::NB_W-1:0] out_nb_r [3];
  logic                            out_valid_r;
  logic                            slot_ok;
  logic [2:0]                      m [3];
  logic                            hit_any;
  logic [1:0]                      hit_pos;
  logic                            not_self;

  assign slot_ok = (32'(in_slot) < MAX_TRIANGLES);

  // Clamp the scan length to the store depth
  always_comb begin
    if (32'(count_r) > MAX_TRIANGLES) begin
      limit = tma_pkg::CNT_W'(MAX_TRIANGLES);
    end else begin
      limit = count_r;
    end
  end

  assign sts.slot_ok    = slot_ok;
  assign sts.limit_zero = (limit == '0);
  assign sts.scan_last  = (scan_idx_r == limit - tma_pkg::CNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  // Triangle store: one write port, one registered read port
  assign rd_addr = cmd.start ? AW'(in_slot) : AW'(scan_idx_r);

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[AW'(in_slot)] <= {in_vertex_c, in_vertex_b, in_vertex_a};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      count_r <= cfg_triangle_count;
    end
  end

  // Scan index and compare-stage tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      issue_d_r  <= 1'b0;
      cmp_idx_r  <= '0;
    end else begin
      issue_d_r <= cmd.issue;
      cmp_idx_r <= scan_idx_r;
      if (cmd.start) begin
        scan_idx_r <= '0;
      end else if (cmd.issue) begin
        scan_idx_r <= scan_idx_r + tma_pkg::CNT_W'(1);
      end
    end
  end

  // Match reversed edges of the scanned triangle against the queried edges
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int e = 0; e < 3; e++) begin
        m[k][e] =
          (q_r[e*VERTEX_BITS +: VERTEX_BITS] ==
           rd_data_r[((k == 2) ? 0 : k + 1)*VERTEX_BITS +: VERTEX_BITS]) &&
          (q_r[((e == 2) ? 0 : e + 1)*VERTEX_BITS +: VERTEX_BITS] ==
           rd_data_r[k*VERTEX_BITS +: VERTEX_BITS]);
      end
    end
  end

  // First scanned edge wins; within it, first queried edge
  always_comb begin
    hit_any = 1'b0;
    hit_pos = 2'd0;
    for (int k = 2; k >= 0; k--) begin
      if (|m[k]) begin
        hit_any = 1'b1;
        hit_pos = m[k][0] ? 2'd0 : (m[k][1] ? 2'd1 : 2'd2);
      end
    end
  end

  assign not_self = (cmp_idx_r != {1'b0, qslot_r});

  // Hold queried triangle and accumulate neighbors
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qslot_r <= in_slot;
      nb_r[0] <= tma_pkg::NB_NONE;
      nb_r[1] <= tma_pkg::NB_NONE;
      nb_r[2] <= tma_pkg::NB_NONE;
    end else if (issue_d_r && hit_any && not_self) begin
      nb_r[hit_pos] <= cmp_idx_r;
    end
    if (cmd.latch_q) begin
      q_r <= rd_data_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_nb_r[0] <= nb_r[0];
      out_nb_r[1] <= nb_r[1];
      out_nb_r[2] <= nb_r[2];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_neighbor_ab = out_nb_r[0];
  assign out_neighbor_bc = out_nb_r[1];
  assign out_neighbor_ca = out_nb_r[2];

endmodule

FILE: design/triangle_mesh_adjacency.sv
// Load transaction: accepted while idle, writes the store, gives no result.
// Query transaction: reads the queried entry, scans L = min(count, depth) entries,
// drains, then gives the result; no scan when L is 0 or for a slot beyond the store.
// The scan does one store read per cycle; new input waits until the query is done.
// Reset (rst_n low, synchronous) clears the controller, result valid and count;
// the triangle store is not cleared.
module triangle_mesh_adjacency #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int VERTEX_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [tma_pkg::SLOT_W-1:0]          in_slot,
  input  logic [VERTEX_BITS-1:0]              in_vertex_a,
  input  logic [VERTEX_BITS-1:0]              in_vertex_b,
  input  logic [VERTEX_BITS-1:0]              in_vertex_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tma_pkg::NB_W-1:0]     out_neighbor_ab,
  output logic signed [tma_pkg::NB_W-1:0]     out_neighbor_bc,
  output logic signed [tma_pkg::NB_W-1:0]     out_neighbor_ca,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tma_pkg::CNT_W-1:0]           cfg_triangle_count
);

  tma_pkg::tma_cmd_t cmd;
  tma_pkg::tma_sts_t sts;

  assign cfg_ready = 1'b1;

  tma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tma_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .VERTEX_BITS   (VERTEX_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_slot            (in_slot),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .in_vertex_c        (in_vertex_c),
    .cfg_valid          (cfg_valid),
    .cfg_triangle_count (cfg_triangle_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbor_ab    (out_neighbor_ab),
    .out_neighbor_bc    (out_neighbor_bc),
    .out_neighbor_ca    (out_neighbor_ca),
    .cmd                (cmd),
    .sts                (sts)
  );

`ifndef NO_ASSERTIONS
  // A result is only moved into a free result register
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result moved into an occupied result register");

  // An accepted query blocks the input on the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == tma_pkg::OP_QUERY)) |=> !in_ready)
    else $error("input accepted while a query is in flight");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.write, cmd.latch_q, cmd.issue, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule
